// ===== src/assert_macros.svh =====
// Assertion macros shared by the pulse train period merger RTL.
// Needs signals named clk and rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PTPM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PTPM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ptpm_pkg.sv =====
// Types and constants for the pulse train period merger.
// No dependencies; used by every module of the block.
package ptpm_pkg;

  // Saturation limit and end marker value of the reload stream.
  localparam logic [31:0] SatMax  = 32'hFFFF_FFFE;
  localparam logic [31:0] EndMark = 32'hFFFF_FFFF;

  // Remainder accumulator: 18-bit two's complement, worked on at 19 bits.
  localparam int RemW = 18;
  localparam int RemWorkW = RemW + 1;
  localparam logic signed [RemWorkW-1:0] RemMax = 19'sd131071;
  localparam logic signed [RemWorkW-1:0] RemMin = -19'sd131072;

  // Configuration register indexes and reset values.
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgRoundingUnit      = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgRoundingThreshold = 1'b1;
  localparam logic [15:0] RoundingUnitRst      = 16'd1562;
  localparam logic [15:0] RoundingThresholdRst = 16'd781;

  typedef struct packed {
    logic [31:0] period_ticks;
    logic        wave_start_level;
    logic        wave_odd_length;
    logic        last_of_wave;
    logic        last_of_sequence;
    logic        following_start_level;
    logic [15:0] wave_remainder;
  } in_item_t;

  typedef struct packed {
    logic [31:0] reload_ticks;
    logic        pin_level;
    logic        end_marker;
  } out_item_t;

  // Result request from the merge stage to the output queue.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_req_t;

  // Status of the merge stage, seen by the top level.
  typedef struct packed {
    logic busy;
    logic started;
  } core_stat_t;

endpackage

// ===== src/ptpm_core.sv =====
// Merge stage: input register, sequence state and the one-pass period merge.
// Depends on ptpm_pkg.
module ptpm_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  ptpm_pkg::in_item_t          in_data,
  input  logic                        cfg_we,
  input  logic [ptpm_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [15:0]                 cfg_wdata,
  input  logic                        q_full,
  output ptpm_pkg::res_req_t          res_req,
  output ptpm_pkg::core_stat_t        stat
);

  localparam int RW = ptpm_pkg::RemWorkW;

  logic [15:0]             unit_r, thresh_r;
  logic                    s1_valid_r;
  ptpm_pkg::in_item_t      s1_item_r;
  logic [31:0]             carry_r, carry_nxt;
  logic signed [ptpm_pkg::RemW-1:0] rsum_r, rsum_nxt;
  logic                    level_r, level_nxt;
  logic                    started_r, started_nxt;

  logic                    advance;
  logic                    lvl, merge, emit;
  logic [31:0]             carry_in, reload, carry_base;
  logic [32:0]             sum33, inc33;
  logic signed [RW-1:0]    rsum_in, rs_add, rs1, rs_sub, rs2;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r   <= ptpm_pkg::RoundingUnitRst;
      thresh_r <= ptpm_pkg::RoundingThresholdRst;
    end else if (cfg_we) begin
      case (cfg_index)
        ptpm_pkg::CfgRoundingUnit:      unit_r   <= cfg_wdata;
        ptpm_pkg::CfgRoundingThreshold: thresh_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The input register empties whenever the output queue has room.
  assign advance  = s1_valid_r && !q_full;
  assign in_ready = !s1_valid_r || !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
  end

  // A new sequence starts from the item's own level with cleared carry and sum.
  assign lvl      = started_r ? level_r : s1_item_r.wave_start_level;
  assign carry_in = started_r ? carry_r : 32'd0;
  assign rsum_in  = started_r ? RW'(rsum_r) : '0;

  // Period plus carry, saturated.
  assign sum33  = {1'b0, s1_item_r.period_ticks} + {1'b0, carry_in};
  assign reload = (sum33 > {1'b0, ptpm_pkg::SatMax}) ? ptpm_pkg::SatMax : sum33[31:0];

  // The last period merges into the next wave when its end level matches.
  assign merge = (s1_item_r.wave_start_level ^ ~s1_item_r.wave_odd_length)
                 == s1_item_r.following_start_level;
  assign carry_base = merge ? reload : 32'd0;
  assign inc33 = {1'b0, carry_base} + 33'd1;

  // Remainder accumulation with clamping on both steps.
  assign rs_add = rsum_in + $signed({{(RW-16){1'b0}}, s1_item_r.wave_remainder});
  assign rs1    = (rs_add > ptpm_pkg::RemMax) ? ptpm_pkg::RemMax : rs_add;
  assign rs_sub = rs1 - $signed({{(RW-16){1'b0}}, unit_r});
  assign rs2    = (rs_sub < ptpm_pkg::RemMin) ? ptpm_pkg::RemMin : rs_sub;

  // Next state and result for the item in the input register.
  always_comb begin
    carry_nxt   = carry_r;
    rsum_nxt    = rsum_r;
    level_nxt   = level_r;
    started_nxt = started_r;
    emit        = 1'b0;
    res_req.item.reload_ticks = reload;
    res_req.item.pin_level    = lvl;
    res_req.item.end_marker   = 1'b0;
    if (advance) begin
      if (s1_item_r.last_of_sequence) begin
        emit        = 1'b1;
        res_req.item.reload_ticks = ptpm_pkg::EndMark;
        res_req.item.end_marker   = 1'b1;
        started_nxt = 1'b0;
        carry_nxt   = 32'd0;
        rsum_nxt    = '0;
        level_nxt   = lvl;
      end else if (s1_item_r.last_of_wave) begin
        emit        = !merge;
        started_nxt = 1'b1;
        level_nxt   = merge ? lvl : ~lvl;
        if (rs1 >= $signed({{(RW-16){1'b0}}, thresh_r})) begin
          rsum_nxt  = rs2[ptpm_pkg::RemW-1:0];
          carry_nxt = (inc33 > {1'b0, ptpm_pkg::SatMax}) ? ptpm_pkg::SatMax : inc33[31:0];
        end else begin
          rsum_nxt  = rs1[ptpm_pkg::RemW-1:0];
          carry_nxt = carry_base;
        end
      end else begin
        emit        = 1'b1;
        started_nxt = 1'b1;
        level_nxt   = ~lvl;
        carry_nxt   = 32'd0;
        rsum_nxt    = rsum_in[ptpm_pkg::RemW-1:0];
      end
    end
    res_req.valid = emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r   <= 32'd0;
      rsum_r    <= '0;
      level_r   <= 1'b0;
      started_r <= 1'b0;
    end else begin
      carry_r   <= carry_nxt;
      rsum_r    <= rsum_nxt;
      level_r   <= level_nxt;
      started_r <= started_nxt;
    end
  end

  assign stat.busy    = s1_valid_r;
  assign stat.started = started_r;

endmodule

// ===== src/ptpm_out_fifo.sv =====
// Two-entry result queue that decouples the merge stage from the consumer.
// Depends on ptpm_pkg.
module ptpm_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  ptpm_pkg::res_req_t  push,
  output logic                full,
  output logic                out_valid,
  input  logic                out_ready,
  output ptpm_pkg::out_item_t out_data
);

  ptpm_pkg::out_item_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != 2'd0);
  assign full      = (count_r == 2'd2);
  assign out_data  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push.valid && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push.valid && pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push.valid) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  // Storage, written only on a push.
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.item;
    end
  end

endmodule

// ===== src/pulse_train_period_merger.sv =====
// Top level of the pulse train period merger: merge stage plus result queue.
// Depends on ptpm_pkg, ptpm_core, ptpm_out_fifo and assert_macros.svh.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | in_data (ptpm_pkg::in_item_t)
//   out     | output    | out_valid / out_ready| out_data (ptpm_pkg::out_item_t)
//   cfg     | input     | cfg_we               | cfg_index, cfg_wdata
//
// One period is taken per cycle unless the input register and the result queue are
// both full; its result, if any, passes the input register and then the result
// queue before it is offered on out_valid. The carried-tick and remainder feedback
// is combinational around its registers, so back-to-back periods run at full rate.
// Reset is synchronous and active low; the result queue holds two entries, and
// input stalls only when both entries are occupied and the input register is full.
`include "assert_macros.svh"

module pulse_train_period_merger (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  ptpm_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output ptpm_pkg::out_item_t          out_data,
  input  logic                         cfg_we,
  input  logic [ptpm_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [15:0]                  cfg_wdata
);

  ptpm_pkg::res_req_t   res_req;
  ptpm_pkg::core_stat_t stat;
  logic                 q_full;

  ptpm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .res_req   (res_req),
    .stat      (stat)
  );

  ptpm_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_req),
    .full      (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The end marker value appears exactly on end-of-transmission results.
  `PTPM_ASSERT_IMP(a_end_value, out_valid && out_data.end_marker, out_data.reload_ticks == ptpm_pkg::EndMark, "end marker without end value")
  `PTPM_ASSERT_IMP(a_reload_sat, out_valid && !out_data.end_marker, out_data.reload_ticks != ptpm_pkg::EndMark, "ordinary reload equals end value")
  // An accepted request always lands in the input register.
  `PTPM_ASSERT_NXT(a_accept_loads, in_valid && in_ready, stat.busy, "accepted request lost")
  // An end marker request closes the running sequence.
  `PTPM_ASSERT_NXT(a_end_closes, res_req.valid && res_req.item.end_marker, !stat.started, "sequence still open after end marker")

endmodule

// ===== sim/pulse_train_period_merger_test.sv =====
// Self-checking testbench for pulse_train_period_merger: sends period requests,
// predicts the reload counts, pin levels and end markers, and checks each result in order.
// Depends on ptpm_pkg and the RTL of the block.
module pulse_train_period_merger_test;

  localparam int ResultLatency = 2;
  localparam int SettleCycles = ResultLatency + 4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  ptpm_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ptpm_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [ptpm_pkg::CfgIdxW-1:0] cfg_index = ptpm_pkg::CfgRoundingUnit;
  logic [15:0] cfg_wdata = '0;

  // Predictor copy of the registers and the merge state.
  logic [15:0] unit_q = ptpm_pkg::RoundingUnitRst;
  logic [15:0] threshold_q = ptpm_pkg::RoundingThresholdRst;
  logic [31:0] carry_ticks = '0;
  logic signed [17:0] rem_sum = '0;
  logic next_level = 1'b0;
  logic train_active = 1'b0;

  ptpm_pkg::out_item_t expected_reloads[$];
  int error_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int period_count = 0;

  pulse_train_period_merger u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard limit on the run in case the block hangs.
  initial begin
    #400000;
    $display("%0t: timeout, results still pending: %0d", $time, expected_reloads.size());
    $display("*** FAILED ***");
    $finish;
  end

  // The receiver stalls at random according to the current idling phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Saturating add at the reload limit.
  function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] wide;
    wide = {1'b0, a} + {1'b0, b};
    return (wide > {1'b0, ptpm_pkg::SatMax}) ? ptpm_pkg::SatMax : wide[31:0];
  endfunction

  // Keep the remainder sum within the 18-bit signed range.
  function automatic int clamp_remainder(input int v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return v;
  endfunction

  // Advance the merge state by one request and queue the result it causes, if any.
  function automatic void merge_period(input ptpm_pkg::in_item_t req);
    logic [31:0] reload;
    logic tail_level;
    int sum;
    ptpm_pkg::out_item_t res;
    if (!train_active) begin
      train_active = 1'b1;
      next_level = req.wave_start_level;
      carry_ticks = '0;
      rem_sum = '0;
    end
    reload = sat_sum(req.period_ticks, carry_ticks);
    carry_ticks = '0;
    res.reload_ticks = reload;
    res.pin_level = next_level;
    res.end_marker = 1'b0;
    if (req.last_of_sequence) begin
      // The final period is dropped along with any carry and remainder.
      res.reload_ticks = ptpm_pkg::EndMark;
      res.end_marker = 1'b1;
      expected_reloads.push_back(res);
      train_active = 1'b0;
      rem_sum = '0;
    end else if (req.last_of_wave) begin
      // Same level across the boundary: the period merges into the next one.
      tail_level = req.wave_start_level ^ ~req.wave_odd_length;
      if (tail_level == req.following_start_level) begin
        carry_ticks = reload;
      end else begin
        expected_reloads.push_back(res);
        next_level = ~next_level;
      end
      sum = clamp_remainder(int'(rem_sum) + int'(req.wave_remainder));
      if (sum >= int'(threshold_q)) begin
        sum = clamp_remainder(sum - int'(unit_q));
        carry_ticks = sat_sum(carry_ticks, 32'd1);
      end
      rem_sum = sum[17:0];
    end else begin
      expected_reloads.push_back(res);
      next_level = ~next_level;
    end
  endfunction

  function automatic void note_mismatch(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    error_count++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
  endfunction

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin : check_results
    ptpm_pkg::out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expected_reloads.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual reload %h level %b end %b",
                 $time, out_data.reload_ticks, out_data.pin_level, out_data.end_marker);
      end else begin
        want = expected_reloads.pop_front();
        if (out_data.reload_ticks !== want.reload_ticks) begin
          note_mismatch("reload_ticks", want.reload_ticks, out_data.reload_ticks);
        end
        if (out_data.pin_level !== want.pin_level) begin
          note_mismatch("pin_level", {31'd0, want.pin_level}, {31'd0, out_data.pin_level});
        end
        if (out_data.end_marker !== want.end_marker) begin
          note_mismatch("end_marker", {31'd0, want.end_marker},
                        {31'd0, out_data.end_marker});
        end
      end
    end
  end

  function automatic ptpm_pkg::in_item_t period_req(input logic [31:0] ticks,
                                                    input logic start_lv,
                                                    input logic odd_len, input logic wave_end,
                                                    input logic seq_end, input logic follow_lv,
                                                    input logic [15:0] rem);
    ptpm_pkg::in_item_t req;
    req.period_ticks = ticks;
    req.wave_start_level = start_lv;
    req.wave_odd_length = odd_len;
    req.last_of_wave = wave_end;
    req.last_of_sequence = seq_end;
    req.following_start_level = follow_lv;
    req.wave_remainder = rem;
    return req;
  endfunction

  // Mostly short periods, with zero, fully random values and values near saturation mixed in.
  function automatic logic [31:0] draw_ticks();
    logic [31:0] t;
    case ($urandom_range(0, 9))
      0: t = '0;
      1: t = ptpm_pkg::SatMax - $urandom_range(0, 15);
      2: t = $urandom;
      default: t = $urandom_range(1, 5000);
    endcase
    if (t == ptpm_pkg::EndMark) t = ptpm_pkg::SatMax;
    return t;
  endfunction

  function automatic logic [15:0] draw_remainder();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3, 4: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, 3000));
    endcase
  endfunction

  // A request with every field random; the period never takes the end marker value.
  function automatic ptpm_pkg::in_item_t noise_req();
    ptpm_pkg::in_item_t req;
    req = period_req($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
    if (req.period_ticks == ptpm_pkg::EndMark) req.period_ticks = ptpm_pkg::SatMax;
    return req;
  endfunction

  // Present one request after random sender idling and wait until it is taken.
  // Valid stays high on return so that a following request can go back to back.
  task automatic push_request(input ptpm_pkg::in_item_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    merge_period(req);
    period_count++;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every expected result, then let a request without a result finish.
  task automatic wait_drained();
    while (expected_reloads.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Write both rounding registers once the block has gone idle.
  task automatic retune(input logic [15:0] unit_val, input logic [15:0] thr_val);
    stop_sending();
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= ptpm_pkg::CfgRoundingUnit;
    cfg_wdata <= unit_val;
    @(posedge clk);
    cfg_index <= ptpm_pkg::CfgRoundingThreshold;
    cfg_wdata <= thr_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    unit_q = unit_val;
    threshold_q = thr_val;
    @(posedge clk);
  endtask

  // A well-formed chain of waveforms with random content, closed by the end request.
  // Now and then the odd-length flag disagrees with the real length.
  task automatic send_train(input int n_waves, input int max_len);
    ptpm_pkg::in_item_t req;
    int len;
    logic start_lv;
    logic odd_flag;
    logic follow_lv;
    for (int w = 0; w < n_waves; w++) begin
      len = int'($urandom_range(1, max_len));
      start_lv = 1'($urandom_range(0, 1));
      odd_flag = len[0];
      if ($urandom_range(0, 15) == 0) odd_flag = ~odd_flag;
      follow_lv = 1'($urandom_range(0, 1));
      for (int p = 0; p < len; p++) begin
        req = noise_req();
        req.period_ticks = draw_ticks();
        req.wave_start_level = start_lv;
        req.wave_odd_length = odd_flag;
        req.last_of_wave = (p == len - 1);
        req.last_of_sequence = (w == n_waves - 1) && (p == len - 1);
        if (p == len - 1) begin
          req.following_start_level = follow_lv;
          req.wave_remainder = draw_remainder();
        end
        push_request(req);
      end
    end
  endtask

  task automatic send_noise(input int count);
    for (int i = 0; i < count; i++) begin
      push_request(noise_req());
    end
  endtask

  // Hand-built trains under the reset rounding values: an end request as the very
  // first period, carries across boundaries, saturation, rounding ticks, ignored
  // start levels and a restart after an end marker.
  task automatic test_directed_trains();
    set_idling(0, 0);
    push_request(period_req(32'd5, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 16'd0));
    push_request(period_req(32'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0));
    push_request(period_req(ptpm_pkg::SatMax, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0));
    push_request(period_req(ptpm_pkg::SatMax, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 16'd781));
    push_request(period_req(32'd7, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 16'd0));
    push_request(period_req(32'd100, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 16'hFFFF));
    push_request(period_req(32'd1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 16'hFFFF));
    push_request(period_req(32'hAAAA_AAAA, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 16'h5555));
    push_request(period_req(32'h5555_5555, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 16'hFFFF));
    push_request(period_req(32'd9, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0));
    push_request(period_req(32'd3, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 16'd0));
    push_request(period_req(32'd0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 16'd0));
    stop_sending();
    wait_drained();
  endtask

  // Rounding registers at their extremes, a zero unit among them, so that the
  // remainder sum runs into its clamp.
  task automatic test_rounding_extremes();
    set_idling(38, 38);
    retune(16'd1, 16'd0);
    repeat (4) send_train($urandom_range(2, 8), 4);
    retune(16'hFFFF, 16'hFFFF);
    repeat (4) send_train($urandom_range(2, 8), 4);
    retune(16'd0, 16'd0);
    repeat (4) send_train($urandom_range(2, 8), 4);
    retune(16'd1, 16'hFFFF);
    repeat (4) send_train($urandom_range(2, 8), 4);
    retune(16'hFFFF, 16'd0);
    repeat (4) send_train($urandom_range(2, 8), 4);
  endtask

  // Random trains and noise through every idling phase, each with fresh rounding values.
  task automatic test_random_trains();
    int goal;
    logic [15:0] unit_val;
    logic [15:0] thr_val;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_idling(0, 0);
        1: set_idling(63, 0);
        2: set_idling(0, 63);
        default: set_idling(38, 38);
      endcase
      unit_val = $urandom_range(0, 1) ? 16'($urandom_range(1, 65535))
                                      : 16'($urandom_range(1, 3000));
      thr_val = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                     : 16'($urandom_range(0, 3000));
      retune(unit_val, thr_val);
      goal = period_count + 300;
      while (period_count < goal) begin
        if ($urandom_range(0, 4) == 0) begin
          send_noise($urandom_range(1, 6));
        end else begin
          send_train($urandom_range(1, 5), $urandom_range(1, 6));
        end
      end
    end
  endtask

  // The sender holds off until the block has delivered every result, then resumes.
  task automatic test_drain_pause();
    set_idling(38, 38);
    repeat (6) begin
      send_train($urandom_range(1, 4), 5);
      stop_sending();
      wait_drained();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_trains();
    test_rounding_extremes();
    test_random_trains();
    test_drain_pause();
    stop_sending();
    wait_drained();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
